### design/mbwr_pkg.sv
package mbwr_pkg;

    // Frame layout and checksum constants.
    localparam logic [7:0]  FN_WRITE_SINGLE = 8'h06;
    localparam logic [15:0] CRC_SEED        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam int          FRAME_LEN       = 8;
    localparam int          IDX_W           = $clog2(FRAME_LEN);

    // Configuration register indexes.
    localparam int          CFG_IDX_W       = 1;
    localparam int          CFG_DATA_W      = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_SLAVE_ID     = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LINK_ENABLED = 1'b1;

    // Result status codes.
    typedef enum logic [1:0] {
        ERR_NONE       = 2'd0,
        ERR_LINK_DOWN  = 2'd1,
        ERR_SLAVE_ZERO = 2'd2
    } err_t;

    // One framing job as handed from the request stage to the serializer.
    typedef struct packed {
        logic [15:0] addr;
        logic [15:0] value;
        logic [7:0]  slave;
        err_t        err;
        logic [31:0] count;
    } job_t;

    // Fold one byte into the Modbus CRC-16, least significant bit first.
    function automatic logic [15:0] crc_byte(input logic [15:0] crc_in,
                                             input logic [7:0]  data);
        logic [15:0] acc;
        acc = crc_in ^ {8'h00, data};
        for (int b = 0; b < 8; b++)
        begin
            if (acc[0])
            begin
                acc = (acc >> 1) ^ CRC_POLY;
            end
            else
            begin
                acc = acc >> 1;
            end
        end
        return acc;
    endfunction

endpackage

### design/mbwr_req_if.sv
interface mbwr_req_if import mbwr_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [15:0] register_address;
    logic [15:0] register_value;

    modport source (output valid, output register_address, output register_value,
                    input ready);
    modport sink (input valid, input register_address, input register_value,
                  output ready);
endinterface

### design/mbwr_res_if.sv
interface mbwr_res_if import mbwr_pkg::*; ();
    logic        valid;
    logic        ready;
    logic [7:0]  frame_byte;
    logic        last_byte;
    logic [1:0]  error_code;
    logic [31:0] frames_sent;

    modport source (output valid, output frame_byte, output last_byte,
                    output error_code, output frames_sent, input ready);
    modport sink (input valid, input frame_byte, input last_byte,
                  input error_code, input frames_sent, output ready);
endinterface

### design/modbus_write_register_framer.sv
// Modbus RTU write-single-register framer with CRC-16.
// The request is held in the request stage register and then loaded into the
// serializer's job register, which sends the frame one byte per cycle while the
// sink is ready; a rejected request yields a single zero byte marked last.
// Reset: slave id 1, link disabled, frame count zero, all stages empty.
module modbus_write_register_framer import mbwr_pkg::*; (
    input  logic                   clk,
    input  logic                   rst_n,
    mbwr_req_if.sink               req,
    mbwr_res_if.source             res,
    input  logic                   cfg_we,
    input  logic [CFG_IDX_W-1:0]   cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    logic [7:0]  slave_id_reg;
    logic        link_enabled_reg;
    logic [31:0] count_reg;
    logic [31:0] count_next;
    logic        held_valid;
    logic [15:0] held_addr;
    logic [15:0] held_value;
    logic        job_ready;
    logic        take;
    job_t        job;

    mbwr_req_stage u_req_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .take       (take),
        .held_valid (held_valid),
        .held_addr  (held_addr),
        .held_value (held_value)
    );

    assign take = held_valid && job_ready;

    // Request check and frame count update.
    always_comb
    begin
        job.addr   = held_addr;
        job.value  = held_value;
        job.slave  = slave_id_reg;
        count_next = count_reg;
        if (!link_enabled_reg)
        begin
            job.err = ERR_LINK_DOWN;
        end
        else if (slave_id_reg == 8'h00)
        begin
            job.err = ERR_SLAVE_ZERO;
        end
        else
        begin
            job.err = ERR_NONE;
        end
        if (take && job.err == ERR_NONE)
        begin
            count_next = count_reg + 32'd1;
        end
        job.count = (job.err == ERR_NONE) ? count_reg + 32'd1 : count_reg;
    end

    // Configuration registers and frame counter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slave_id_reg     <= 8'd1;
            link_enabled_reg <= 1'b0;
            count_reg        <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_SLAVE_ID:     slave_id_reg     <= cfg_data[7:0];
                    CFG_LINK_ENABLED: link_enabled_reg <= cfg_data[0];
                    default:          ;
                endcase
            end
        end
    end

    mbwr_serializer u_serializer (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (held_valid),
        .job_ready (job_ready),
        .job       (job),
        .res       (res)
    );

endmodule

### design/mbwr_req_stage.sv
module mbwr_req_stage import mbwr_pkg::*; (
    input  logic         clk,
    input  logic         rst_n,
    mbwr_req_if.sink     req,
    input  logic         take,
    output logic         held_valid,
    output logic [15:0]  held_addr,
    output logic [15:0]  held_value
);

    logic        valid_reg;
    logic        valid_next;
    logic [15:0] addr_reg;
    logic [15:0] value_reg;
    logic        accept;

    // The register is free when empty or when its item leaves this cycle.
    assign req.ready  = !valid_reg || take;
    assign accept     = req.valid && req.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (accept)
        begin
            valid_next = 1'b1;
        end
        else if (take)
        begin
            valid_next = 1'b0;
        end
    end

    // Valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Payload capture.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            addr_reg  <= req.register_address;
            value_reg <= req.register_value;
        end
    end

    assign held_valid = valid_reg;
    assign held_addr  = addr_reg;
    assign held_value = value_reg;

endmodule

### design/mbwr_serializer.sv
module mbwr_serializer import mbwr_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        job_valid,
    output logic        job_ready,
    input  job_t        job,
    mbwr_res_if.source  res
);

    localparam logic [IDX_W-1:0] POS_SLAVE   = IDX_W'(0);
    localparam logic [IDX_W-1:0] POS_FUNC    = IDX_W'(1);
    localparam logic [IDX_W-1:0] POS_ADDR_HI = IDX_W'(2);
    localparam logic [IDX_W-1:0] POS_ADDR_LO = IDX_W'(3);
    localparam logic [IDX_W-1:0] POS_VAL_HI  = IDX_W'(4);
    localparam logic [IDX_W-1:0] POS_VAL_LO  = IDX_W'(5);
    localparam logic [IDX_W-1:0] POS_CRC_LO  = IDX_W'(6);
    localparam logic [IDX_W-1:0] POS_CRC_HI  = IDX_W'(FRAME_LEN - 1);

    logic             busy_reg;
    logic             busy_next;
    job_t             job_reg;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic [15:0]      crc_reg;
    logic [15:0]      crc_next;
    logic [7:0]       cur_byte;
    logic             cur_last;
    logic             fire;
    logic             load;

    // Byte selection for the current frame position.
    always_comb
    begin
        case (idx_reg)
            POS_SLAVE:   cur_byte = job_reg.slave;
            POS_FUNC:    cur_byte = FN_WRITE_SINGLE;
            POS_ADDR_HI: cur_byte = job_reg.addr[15:8];
            POS_ADDR_LO: cur_byte = job_reg.addr[7:0];
            POS_VAL_HI:  cur_byte = job_reg.value[15:8];
            POS_VAL_LO:  cur_byte = job_reg.value[7:0];
            POS_CRC_LO:  cur_byte = crc_reg[7:0];
            POS_CRC_HI:  cur_byte = crc_reg[15:8];
            default:     cur_byte = 8'h00;
        endcase
        if (job_reg.err != ERR_NONE)
        begin
            cur_byte = 8'h00;
        end
    end

    assign cur_last  = (job_reg.err != ERR_NONE) || (idx_reg == POS_CRC_HI);
    assign fire      = res.valid && res.ready;
    assign job_ready = !busy_reg || (fire && cur_last);
    assign load      = job_valid && job_ready;

    // Sequencing: a new job loads as the previous one's last item leaves.
    always_comb
    begin
        busy_next = busy_reg;
        idx_next  = idx_reg;
        crc_next  = crc_reg;
        if (load)
        begin
            busy_next = 1'b1;
            idx_next  = POS_SLAVE;
            crc_next  = CRC_SEED;
        end
        else if (fire)
        begin
            if (cur_last)
            begin
                busy_next = 1'b0;
            end
            else
            begin
                idx_next = idx_reg + IDX_W'(1);
                if (idx_reg < POS_CRC_LO)
                begin
                    crc_next = crc_byte(crc_reg, cur_byte);
                end
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            idx_reg  <= idx_next;
        end
    end

    // Job payload and running checksum.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            job_reg <= job;
        end
        crc_reg <= crc_next;
    end

    assign res.valid       = busy_reg;
    assign res.frame_byte  = cur_byte;
    assign res.last_byte   = cur_last;
    assign res.error_code  = job_reg.err;
    assign res.frames_sent = job_reg.count;

endmodule
